[design/configurable_crc32_64bit_word_top_assert.svh]
// Assertion macros for the word CRC block.
`ifndef CONFIGURABLE_CRC32_64BIT_WORD_TOP_ASSERT_SVH
`define CONFIGURABLE_CRC32_64BIT_WORD_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CRCW_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define CRCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CRCW_ASSERT_NOW(lbl, expr, msg)
`define CRCW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/crc32w_pkg.sv]
package crc32w_pkg;

    localparam int CRC_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int NUM_BYTES  = 8;
    localparam int DATA_W     = NUM_BYTES * BYTE_W;
    localparam int IN_TDATA_W = DATA_W + CRC_W;
    localparam int TOP_SHIFT  = CRC_W - BYTE_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CRC_W-1:0] POLY_RESET    = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] XOR_OUT_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLY     = 2'd0,
        CFG_XOR_OUT  = 2'd1,
        CFG_REFL_IN  = 2'd2,
        CFG_REFL_OUT = 2'd3
    } t_cfg_idx;

    function automatic logic [BYTE_W-1:0] rev_byte(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] rev_word(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    // One byte through the MSB-first shift register, eight polynomial steps.
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {data, {TOP_SHIFT{1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ poly) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[design/configurable_crc32_64bit_word_top.sv]
// Configurable CRC-32 over one 64-bit word per request.
//
// Input stream (s_axis): each request carries a 64-bit data word and a start
// CRC; bytes are folded in least significant byte first. Output stream
// (m_axis): one 32-bit CRC per request, in request order.
// Config channel (i_cfg_*): index 0 polynomial, 1 final XOR, 2 reflect input
// bytes, 3 reflect output word. Always ready; write only while idle.
//
// Pipeline: a request passes an input register, eight byte stages and an output
// register before it shows on m_axis. Throughput: one request per cycle while
// m_axis does not stall; each stage folds one byte (eight shift steps) into the
// CRC, which sets the logic depth between registers.
//
// Reset (synchronous, active low) empties the pipeline and loads the standard
// CRC-32 polynomial with no reflection and zero final XOR.
// When m_axis stalls, the result holds on the output register while earlier
// stages keep filling empty slots; s_axis_tready drops only once every stage
// holds a request.
module configurable_crc32_64bit_word_top
    import crc32w_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [63:0] data_word, [95:64] start_crc
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] crc_result
    output logic [CRC_W-1:0]      m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CRC_W-1:0]      i_cfg_data
);

    logic [CRC_W-1:0] r_poly;
    logic [CRC_W-1:0] r_xor_out;
    logic             r_refl_in;
    logic             r_refl_out;

    logic             r_vld  [0:NUM_BYTES];
    logic [CRC_W-1:0] r_crc  [0:NUM_BYTES];
    logic [DATA_W-1:0] r_data [0:NUM_BYTES-1];
    logic             s_rdy  [0:NUM_BYTES];
    logic [CRC_W-1:0] n_crc  [1:NUM_BYTES];

    logic             r_out_vld;
    logic [CRC_W-1:0] r_out;
    logic             out_rdy;
    logic [CRC_W-1:0] n_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly     <= POLY_RESET;
            r_xor_out  <= XOR_OUT_RESET;
            r_refl_in  <= 1'b0;
            r_refl_out <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POLY:     r_poly     <= i_cfg_data;
                CFG_XOR_OUT:  r_xor_out  <= i_cfg_data;
                CFG_REFL_IN:  r_refl_in  <= i_cfg_data[0];
                CFG_REFL_OUT: r_refl_out <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // A stage can take a request if it is empty or its content moves on.
    assign out_rdy = !r_out_vld || m_axis_tready;

    always_comb begin
        s_rdy[NUM_BYTES] = !r_vld[NUM_BYTES] || out_rdy;
        for (int k = NUM_BYTES - 1; k >= 0; k--) begin
            s_rdy[k] = !r_vld[k] || s_rdy[k+1];
        end
    end

    assign s_axis_tready = s_rdy[0];

    always_comb begin
        for (int k = 1; k <= NUM_BYTES; k++) begin
            n_crc[k] = crc_byte(r_crc[k-1],
                                r_refl_in ? rev_byte(r_data[k-1][BYTE_W-1:0])
                                          : r_data[k-1][BYTE_W-1:0],
                                r_poly);
        end
    end

    assign n_out = (r_refl_out ? rev_word(r_crc[NUM_BYTES]) : r_crc[NUM_BYTES]) ^ r_xor_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NUM_BYTES; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else begin
            if (s_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k <= NUM_BYTES; k++) begin
                if (s_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (out_rdy) begin
                r_out_vld <= r_vld[NUM_BYTES];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[0] && s_axis_tvalid) begin
            r_data[0] <= s_axis_tdata[DATA_W-1:0];
            r_crc[0]  <= s_axis_tdata[IN_TDATA_W-1:DATA_W];
        end
        for (int k = 1; k <= NUM_BYTES; k++) begin
            if (s_rdy[k] && r_vld[k-1]) begin
                r_crc[k] <= n_crc[k];
            end
        end
        // the last stage needs no data bytes
        for (int k = 1; k < NUM_BYTES; k++) begin
            if (s_rdy[k] && r_vld[k-1]) begin
                r_data[k] <= r_data[k-1] >> BYTE_W;
            end
        end
        if (out_rdy && r_vld[NUM_BYTES]) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

`include "configurable_crc32_64bit_word_top_assert.svh"

    `CRCW_ASSERT_NEXT(a_take_fills_first, s_axis_tvalid && s_axis_tready, r_vld[0], "accepted request not in first stage")
    `CRCW_ASSERT_NOW(a_full_when_blocked, s_axis_tready || (r_out_vld && r_vld[NUM_BYTES] && r_vld[0]), "input blocked with room in pipeline")
    `CRCW_ASSERT_NEXT(a_last_stage_holds, r_vld[NUM_BYTES] && r_out_vld && !m_axis_tready, r_vld[NUM_BYTES] && r_out_vld, "request lost under output stall")

endmodule

[tb/tb_configurable_crc32_64bit_word_top.sv]
`timescale 1ns / 1ps

module tb_configurable_crc32_64bit_word_top;
    import crc32w_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RX_HOLD_LEN   = 80;
    localparam int REPORT_MAX    = 10;

    // packed so that it lines up with s_axis_tdata: data_word low, start_crc high
    typedef struct packed {
        logic [CRC_W-1:0]  start_crc;
        logic [DATA_W-1:0] data_word;
    } t_crc_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [CRC_W-1:0]      m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CRC_W-1:0]      i_cfg_data = '0;

    // local copy of the block's registers
    logic [CRC_W-1:0] cur_poly = POLY_RESET;
    logic [CRC_W-1:0] cur_xor_out = XOR_OUT_RESET;
    logic             cur_refl_in = 1'b0;
    logic             cur_refl_out = 1'b0;

    t_crc_req         crc_req_queue[$];
    logic [CRC_W-1:0] crc_expected[$];

    int  reqs_pushed = 0;
    int  reqs_taken = 0;
    int  mismatch_cnt = 0;
    int  cycle_cnt = 0;
    int  tx_gap_left = 0;
    int  rx_stall_left = 0;
    int  rx_hold_left = 0;
    bit  idle_en = 1'b1;
    bit  rx_hold_req = 1'b0;

    configurable_crc32_64bit_word_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [63:0] data_word, [95:64] start_crc
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] crc_result
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // bytes LSB first, each optionally bit-reversed, shifted MSB first
    function automatic logic [CRC_W-1:0] calc_word_crc(input logic [DATA_W-1:0] data,
                                                       input logic [CRC_W-1:0] seed);
        logic [CRC_W-1:0]  c;
        logic [CRC_W-1:0]  r;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] rb;
        c = seed;
        for (int i = 0; i < NUM_BYTES; i++) begin
            b = data[BYTE_W*i +: BYTE_W];
            if (cur_refl_in) begin
                for (int j = 0; j < BYTE_W; j++) rb[BYTE_W-1-j] = b[j];
                b = rb;
            end
            c = c ^ {b, 24'h0};
            for (int k = 0; k < BYTE_W; k++) begin
                if (c[CRC_W-1]) c = {c[CRC_W-2:0], 1'b0} ^ cur_poly;
                else c = {c[CRC_W-2:0], 1'b0};
            end
        end
        if (cur_refl_out) begin
            for (int j = 0; j < CRC_W; j++) r[CRC_W-1-j] = c[j];
            c = r;
        end
        return c ^ cur_xor_out;
    endfunction

    function automatic t_crc_req rand_req();
        t_crc_req r;
        r.data_word = {$urandom, $urandom};
        r.start_crc = $urandom;
        case ($urandom_range(0, 11))
            0: r.data_word = '0;
            1: r.data_word = '1;
            2: r.start_crc = '0;
            3: r.start_crc = '1;
            4: r.data_word = {56'h0, 8'($urandom)};
            default: ;
        endcase
        return r;
    endfunction

    task automatic push_req(input logic [DATA_W-1:0] data, input logic [CRC_W-1:0] seed);
        t_crc_req r;
        r.data_word = data;
        r.start_crc = seed;
        crc_req_queue.push_back(r);
        reqs_pushed++;
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++) begin
            crc_req_queue.push_back(rand_req());
            reqs_pushed++;
        end
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CRC_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_POLY:     cur_poly = val;
            CFG_XOR_OUT:  cur_xor_out = val;
            CFG_REFL_IN:  cur_refl_in = val[0];
            CFG_REFL_OUT: cur_refl_out = val[0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(input logic [CRC_W-1:0] poly, input logic [CRC_W-1:0] xo,
                           input logic [CRC_W-1:0] rin, input logic [CRC_W-1:0] rout);
        cfg_write(CFG_POLY, poly);
        cfg_write(CFG_XOR_OUT, xo);
        cfg_write(CFG_REFL_IN, rin);
        cfg_write(CFG_REFL_OUT, rout);
    endtask

    // every request taken and answered, then let the pipeline settle
    task automatic wait_drained();
        @(posedge i_clk);
        while (reqs_taken != reqs_pushed || crc_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                crc_expected.push_back(calc_word_crc(s_axis_tdata[DATA_W-1:0],
                                                     s_axis_tdata[IN_TDATA_W-1:DATA_W]));
                reqs_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (idle_en && $urandom_range(0, 5) == 0) begin
                    tx_gap_left = $urandom_range(0, 4);
                    s_axis_tvalid <= 1'b0;
                end else if (crc_req_queue.size() > 0) begin
                    s_axis_tdata  <= crc_req_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (crc_expected.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("unexpected result %h at %0t", m_axis_tdata, $realtime);
                end else if (m_axis_tdata !== crc_expected[0]) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("crc_result mismatch: expected %h got %h at %0t",
                                 crc_expected[0], m_axis_tdata, $realtime);
                    void'(crc_expected.pop_front());
                end else begin
                    void'(crc_expected.pop_front());
                end
            end
            if (rx_hold_req) begin
                rx_hold_req <= 1'b0;
                rx_hold_left = RX_HOLD_LEN;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_stall_left > 0) begin
                rx_stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                rx_stall_left = $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: plain CRC-32 polynomial, no reflection, zero final XOR
        push_req(64'h0, 32'h0);
        push_req(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        push_req(64'h0000_0000_0000_0001, 32'h0);
        push_req(64'h8000_0000_0000_0000, 32'h0);
        push_req(64'h0, 32'h8000_0000);
        push_req(64'h0, 32'h0000_0001);
        push_req(64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
        push_req(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
        push_req(64'h0102_0408_1020_4080, 32'hFFFF_FFFF);
        push_req(64'hFF00_FF00_FF00_FF00, 32'h0000_FFFF);
        push_req(64'h3837_3635_3433_3231, 32'hFFFF_FFFF);
        push_random(100);
        wait_drained();

        // reflected in and out, all-ones final XOR
        cfg_all(32'h04C1_1DB7, 32'hFFFF_FFFF, 32'h1, 32'h1);
        push_req(64'h3837_3635_3433_3231, 32'hFFFF_FFFF);
        push_req(64'h0, 32'hFFFF_FFFF);
        push_req(64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        push_req(64'h0000_0000_0000_0080, 32'h0);
        push_req(64'h0100_0000_0000_0000, 32'h1234_5678);
        push_random(120);
        wait_drained();

        // zero polynomial: plain shift, nothing folded back
        cfg_all(32'h0, 32'h0, 32'h0, 32'h0);
        push_req(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        push_req(64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF);
        push_random(100);
        wait_drained();

        // all-ones polynomial; upper data bits on the flag writes are dropped
        cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        push_req(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        push_req(64'h0, 32'h0);
        push_random(100);
        wait_drained();

        // receiver holds off while requests keep coming, so the pipe backs up
        cfg_all(32'h1EDC_6F41, 32'hFFFF_FFFF, 32'h1, 32'h1);
        push_random(150);
        @(posedge i_clk);
        rx_hold_req <= 1'b1;
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            cfg_all($urandom, ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom,
                    $urandom, $urandom);
            push_random(120);
            wait_drained();
        end

        // back to back at full rate
        idle_en = 1'b0;
        cfg_all($urandom, $urandom, $urandom, $urandom);
        push_random(150);
        wait_drained();

        if (mismatch_cnt == 0 && crc_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/crc32w_pkg.sv
design/configurable_crc32_64bit_word_top.sv
tb/tb_configurable_crc32_64bit_word_top.sv
